[src/bfsa_pkg.sv]
// Shared types and constants of the best-fit segment allocator.
`timescale 1ns / 1ps
`default_nettype none
package bfsa_pkg;

  localparam int unsigned DVD_W = 64;                 // dividend width of the divider
  localparam int unsigned DVS_W = 21;                 // divisor width (unit size)
  localparam int unsigned CNT_W = $clog2(DVD_W + 1);  // divider step counter width
  localparam int unsigned BYTES_W = 31;               // bytes-in-use result width

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOFIT   = 3'd2,
    ST_BADADDR = 3'd3,
    ST_DBLFREE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    US_INTERIOR = 2'd0,
    US_FREE     = 2'd1,
    US_FULL     = 2'd2
  } ustat_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

endpackage
`default_nettype wire

[src/bfsa_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bfsa_div (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  input  wire [bfsa_pkg::DVD_W-1:0]  dividend_i,
  input  wire [bfsa_pkg::DVS_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [bfsa_pkg::DVD_W-1:0] quotient_o,
  output logic [bfsa_pkg::DVS_W-1:0] remainder_o
);
  import bfsa_pkg::*;

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem_q, quo_q[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    done_d  = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sub[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a running division");
  a_no_start_lost : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("divider did not start");
  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < dvs_q) else $error("remainder not below divisor");

endmodule
`default_nettype wire

[src/best_fit_segment_allocator_core.sv]
// Top level of the best-fit segment allocator: sequencer, tag memories, config port.
`timescale 1ns / 1ps
`default_nettype none
// The allocator manages a zone of NUM_UNITS equal units. A transaction is taken
// when start is high and busy is low; it is either an allocate (request_bytes
// rounded up to units, best-fit class search, remainder split off) or a free
// (segment returned and merged with free neighbors through boundary tags).
// Exactly one result follows each transaction, shown for one cycle with
// result_valid_o high; the receiver cannot stall it. Every transaction first
// runs the shared 64-step divider, which turns the byte size or the address
// offset into units. A request rejected by the division (zero size,
// oversized, bad address) goes straight to its result. An allocate
// then scans size classes one by one, from the requested size upward, and
// looks at most at NUM_UNITS classes. A free is rejected as a double free
// or an interior unit, or succeeds with the list updates of up to two merges.
// After reset the block runs a clearing pass over the status and class
// memories, with busy high; configuration writes are taken meanwhile.
// Registers on the APB port: unit_bytes at 0x0 and zone_base at 0x8; they must
// only be written while the block is idle.
module best_fit_segment_allocator_core #(
  parameter int unsigned NUM_UNITS = 1024
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  wire                          command_i,
  input  wire  [31:0]                  request_bytes_i,
  input  wire  [63:0]                  release_address_i,
  output logic                         result_valid_o,
  output logic [2:0]                   status_o,
  output logic [63:0]                  granted_address_o,
  output logic [bfsa_pkg::BYTES_W-1:0] bytes_in_use_o,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [3:0]                   paddr,
  input  wire  [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);
  import bfsa_pkg::*;

  localparam int unsigned AW = $clog2(NUM_UNITS);
  localparam int unsigned LW = $clog2(NUM_UNITS + 1);
  localparam int unsigned PW = LW + DVS_W;
  localparam logic [LW-1:0] NO_LINK = LW'(NUM_UNITS);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DIV, S_SCAN_RD, S_SCAN_CK, S_RM0, S_RM1, S_PU0, S_PU1,
    S_PU2, S_A_W1, S_A_W2, S_F_RD, S_F_CK, S_F_P, S_F_PC, S_F_PM, S_F_N,
    S_F_NC, S_F_NM, S_F_B, S_MUL1, S_MUL2, S_RESP
  } state_e;

  // Configuration registers.
  logic [DVS_W-1:0] unit_bytes_q;
  logic [63:0]      zone_base_q;
  logic             cfg_wr;
  logic [DVS_W-1:0] unit_sz;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = paddr[3] ? zone_base_q : {{(64 - DVS_W){1'b0}}, unit_bytes_q};
  assign unit_sz = (unit_bytes_q == '0) ? DVS_W'(1) : unit_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_bytes_q <= DVS_W'(64);
      zone_base_q  <= '0;
    end else if (cfg_wr) begin
      if (paddr[3]) begin
        zone_base_q <= pwdata;
      end else begin
        unit_bytes_q <= pwdata[DVS_W-1:0];
      end
    end
  end

  // Sequencer registers.
  state_e           state_q;
  state_e           ret_q;
  logic [LW-1:0]    clr_q;
  cmd_e             cmd_q;
  status_e          status_q;
  logic [LW-1:0]    n_q, s_q, scan_q, len_q, nl_q, nxt_q, held_q;
  logic [AW-1:0]    seg_q, cur_q, p_q, h_q;
  logic [AW-1:0]    sub_seg_q;
  logic [LW-1:0]    sub_len_q;
  logic [PW-1:0]    prod_q;
  logic [63:0]      gaddr_q;
  logic             res_vld_q;
  logic [2:0]       res_status_q;
  logic [63:0]      res_addr_q;
  logic [BYTES_W-1:0] res_bytes_q;

  // Divider.
  logic             accept;
  logic             div_done;
  logic [DVD_W-1:0] div_q;
  logic [DVS_W-1:0] div_r;
  logic [63:0]      offset;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign offset = release_address_i - zone_base_q;

  bfsa_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .dividend_i  (command_i ? offset : {32'd0, request_bytes_i}),
    .divisor_i   (unit_sz),
    .done_o      (div_done),
    .quotient_o  (div_q),
    .remainder_o (div_r)
  );

  // Tag memories: one write and one registered read per cycle each.
  logic [1:0]    ust_mem   [NUM_UNITS];
  logic [LW-1:0] slen_mem  [NUM_UNITS];
  logic [LW-1:0] bd_mem    [NUM_UNITS];
  logic [LW-1:0] lfw_mem   [NUM_UNITS];
  logic [LW-1:0] lbw_mem   [NUM_UNITS];
  logic [AW:0]   ch_mem    [NUM_UNITS + 1];

  logic          ust_we, slen_we, bd_we, lfw_we, lbw_we, ch_we;
  logic [AW-1:0] ust_wa, slen_wa, bd_wa, lfw_wa, lbw_wa;
  logic [LW-1:0] ch_wa;
  logic [1:0]    ust_wd;
  logic [LW-1:0] slen_wd, bd_wd, lfw_wd, lbw_wd;
  logic [AW:0]   ch_wd;
  logic [AW-1:0] ust_ra, slen_ra, bd_ra, lk_ra;
  logic [LW-1:0] ch_ra;
  logic [1:0]    ust_rd;
  logic [LW-1:0] slen_rd, bd_rd, lfw_rd, lbw_rd;
  logic [AW:0]   ch_rd;
  logic          ch_v;
  logic [AW-1:0] ch_h;

  assign ch_v = ch_rd[AW];
  assign ch_h = ch_rd[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (ust_we) ust_mem[ust_wa] <= ust_wd;
    if (slen_we) slen_mem[slen_wa] <= slen_wd;
    if (bd_we) bd_mem[bd_wa] <= bd_wd;
    if (lfw_we) lfw_mem[lfw_wa] <= lfw_wd;
    if (lbw_we) lbw_mem[lbw_wa] <= lbw_wd;
    if (ch_we) ch_mem[ch_wa] <= ch_wd;
    ust_rd  <= ust_mem[ust_ra];
    slen_rd <= slen_mem[slen_ra];
    bd_rd   <= bd_mem[bd_ra];
    lfw_rd  <= lfw_mem[lk_ra];
    lbw_rd  <= lbw_mem[lk_ra];
    ch_rd   <= ch_mem[ch_ra];
  end

  // Derived values used by both the memory control and the sequencer.
  logic [LW-1:0] seg_ext, cur_ext, sum_seg_s, sum_seg_n, sum_cur_len;
  logic [LW-1:0] s_minus_n, merged_prev, merged_next;
  logic          q_too_big;

  assign seg_ext     = LW'(seg_q);
  assign cur_ext     = LW'(cur_q);
  assign sum_seg_s   = seg_ext + s_q;
  assign sum_seg_n   = seg_ext + n_q;
  assign sum_cur_len = cur_ext + slen_rd;
  assign s_minus_n   = s_q - n_q;
  assign merged_prev = nl_q + len_q;
  assign merged_next = len_q + nl_q;
  assign q_too_big   = (div_q > 64'(NUM_UNITS)) ||
                       ((div_q == 64'(NUM_UNITS)) && (div_r != '0));

  // Memory read addresses and write strobes per sequencer step.
  always_comb begin
    ust_we = 1'b0;  ust_wa = '0;  ust_wd = US_INTERIOR;
    slen_we = 1'b0; slen_wa = '0; slen_wd = '0;
    bd_we = 1'b0;   bd_wa = '0;   bd_wd = '0;
    lfw_we = 1'b0;  lfw_wa = '0;  lfw_wd = '0;
    lbw_we = 1'b0;  lbw_wa = '0;  lbw_wd = '0;
    ch_we = 1'b0;   ch_wa = '0;   ch_wd = '0;
    ust_ra = cur_q; slen_ra = cur_q; bd_ra = cur_q; lk_ra = sub_seg_q;
    ch_ra = scan_q;
    case (state_q)
      S_CLR: begin
        ch_we = 1'b1;
        ch_wa = clr_q;
        ch_wd = (clr_q == NO_LINK) ? {1'b1, AW'(0)} : '0;
        if (clr_q != NO_LINK) begin
          ust_we = 1'b1;
          ust_wa = clr_q[AW-1:0];
          ust_wd = (clr_q == '0) ? US_FREE : US_INTERIOR;
        end
        // Segment 0 starts as the only entry of the full-zone class.
        if (clr_q == '0) begin
          slen_we = 1'b1;
          slen_wa = '0;
          slen_wd = NO_LINK;
          lfw_we  = 1'b1;
          lfw_wa  = '0;
          lfw_wd  = NO_LINK;
          lbw_we  = 1'b1;
          lbw_wa  = '0;
          lbw_wd  = NO_LINK;
        end
      end
      S_RM1: begin
        if (lbw_rd < NO_LINK) begin
          lfw_we = 1'b1;
          lfw_wa = lbw_rd[AW-1:0];
          lfw_wd = lfw_rd;
        end else begin
          ch_we = 1'b1;
          ch_wa = sub_len_q;
          ch_wd = (lfw_rd < NO_LINK) ? {1'b1, lfw_rd[AW-1:0]} : '0;
        end
        if (lfw_rd < NO_LINK) begin
          lbw_we = 1'b1;
          lbw_wa = lfw_rd[AW-1:0];
          lbw_wd = lbw_rd;
        end
      end
      S_PU0: ch_ra = sub_len_q;
      S_PU1: begin
        lbw_we = 1'b1;
        lbw_wa = sub_seg_q;
        lbw_wd = NO_LINK;
        lfw_we = 1'b1;
        lfw_wa = sub_seg_q;
        lfw_wd = ch_v ? LW'(ch_h) : NO_LINK;
        ch_we  = 1'b1;
        ch_wa  = sub_len_q;
        ch_wd  = {1'b1, sub_seg_q};
      end
      S_PU2: begin
        lbw_we = 1'b1;
        lbw_wa = h_q;
        lbw_wd = LW'(sub_seg_q);
      end
      S_A_W1: begin
        ust_we  = 1'b1;
        ust_wa  = seg_q;
        ust_wd  = US_FULL;
        slen_we = 1'b1;
        slen_wa = seg_q;
        slen_wd = n_q;
        if ((s_q > n_q) && (sum_seg_s < NO_LINK)) begin
          bd_we = 1'b1;
          bd_wa = sum_seg_s[AW-1:0];
          bd_wd = s_minus_n;
        end
      end
      S_A_W2: begin
        ust_we  = 1'b1;
        ust_wa  = sum_seg_n[AW-1:0];
        ust_wd  = US_FREE;
        bd_we   = 1'b1;
        bd_wa   = sum_seg_n[AW-1:0];
        bd_wd   = n_q;
        slen_we = 1'b1;
        slen_wa = sum_seg_n[AW-1:0];
        slen_wd = s_minus_n;
      end
      S_F_CK: begin
        if (ust_rd == US_FULL) begin
          ust_we = 1'b1;
          ust_wa = cur_q;
          ust_wd = US_FREE;
        end
      end
      S_F_P: begin
        ust_ra  = p_q;
        slen_ra = p_q;
      end
      S_F_PM: begin
        slen_we = 1'b1;
        slen_wa = p_q;
        slen_wd = merged_prev;
        ust_we  = 1'b1;
        ust_wa  = cur_q;
        ust_wd  = US_INTERIOR;
      end
      S_F_N: begin
        ust_ra  = nxt_q[AW-1:0];
        slen_ra = nxt_q[AW-1:0];
      end
      S_F_NM: begin
        slen_we = 1'b1;
        slen_wa = cur_q;
        slen_wd = merged_next;
        ust_we  = 1'b1;
        ust_wa  = nxt_q[AW-1:0];
        ust_wd  = US_INTERIOR;
      end
      S_F_B: begin
        if (nxt_q < NO_LINK) begin
          bd_we = 1'b1;
          bd_wa = nxt_q[AW-1:0];
          bd_wd = len_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Product widened to 64 bits; it is saturated to the result width when registered.
  logic [63:0] prod_ext;
  assign prod_ext = 64'(prod_q);

  // Sequencer state and registered results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      ret_q        <= S_IDLE;
      clr_q        <= '0;
      cmd_q        <= CMD_ALLOC;
      status_q     <= ST_OK;
      n_q          <= '0;
      s_q          <= '0;
      scan_q       <= '0;
      len_q        <= '0;
      nl_q         <= '0;
      nxt_q        <= '0;
      held_q       <= '0;
      seg_q        <= '0;
      cur_q        <= '0;
      p_q          <= '0;
      h_q          <= '0;
      sub_seg_q    <= '0;
      sub_len_q    <= '0;
      prod_q       <= '0;
      gaddr_q      <= '0;
      res_vld_q    <= 1'b0;
      res_status_q <= '0;
      res_addr_q   <= '0;
      res_bytes_q  <= '0;
    end else begin
      res_vld_q <= 1'b0;
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == NO_LINK) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_q    <= cmd_e'(command_i);
            status_q <= ST_OK;
            state_q  <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (cmd_q == CMD_ALLOC) begin
              if ((div_q == '0) && (div_r == '0)) begin
                status_q <= ST_ZERO;
                state_q  <= S_MUL1;
              end else if (q_too_big) begin
                status_q <= ST_NOFIT;
                state_q  <= S_MUL1;
              end else begin
                n_q     <= div_q[LW-1:0] + LW'(div_r != '0);
                scan_q  <= div_q[LW-1:0] + LW'(div_r != '0);
                state_q <= S_SCAN_RD;
              end
            end else begin
              if ((div_r != '0) || (div_q >= 64'(NUM_UNITS))) begin
                status_q <= ST_BADADDR;
                state_q  <= S_MUL1;
              end else begin
                cur_q   <= div_q[AW-1:0];
                state_q <= S_F_RD;
              end
            end
          end
        end
        S_SCAN_RD: state_q <= S_SCAN_CK;
        S_SCAN_CK: begin
          if (ch_v) begin
            seg_q     <= ch_h;
            s_q       <= scan_q;
            sub_seg_q <= ch_h;
            sub_len_q <= scan_q;
            ret_q     <= S_A_W1;
            state_q   <= S_RM0;
          end else if (scan_q == NO_LINK) begin
            status_q <= ST_NOFIT;
            state_q  <= S_MUL1;
          end else begin
            scan_q  <= scan_q + 1'b1;
            state_q <= S_SCAN_RD;
          end
        end
        S_RM0: state_q <= S_RM1;
        S_RM1: state_q <= ret_q;
        S_PU0: state_q <= S_PU1;
        S_PU1: begin
          h_q     <= ch_h;
          state_q <= ch_v ? S_PU2 : ret_q;
        end
        S_PU2: state_q <= ret_q;
        S_A_W1: begin
          held_q  <= held_q + n_q;
          state_q <= (s_q > n_q) ? S_A_W2 : S_MUL1;
        end
        S_A_W2: begin
          sub_seg_q <= sum_seg_n[AW-1:0];
          sub_len_q <= s_minus_n;
          ret_q     <= S_MUL1;
          state_q   <= S_PU0;
        end
        S_F_RD: state_q <= S_F_CK;
        S_F_CK: begin
          if (ust_rd == US_FREE) begin
            status_q <= ST_DBLFREE;
            state_q  <= S_MUL1;
          end else if (ust_rd != US_FULL) begin
            status_q <= ST_BADADDR;
            state_q  <= S_MUL1;
          end else begin
            len_q  <= slen_rd;
            held_q <= (held_q >= slen_rd) ? held_q - slen_rd : '0;
            nxt_q  <= sum_cur_len;
            if ((cur_q != '0) && (bd_rd <= cur_ext) && (bd_rd != '0)) begin
              p_q     <= cur_q - bd_rd[AW-1:0];
              state_q <= S_F_P;
            end else begin
              state_q <= S_F_N;
            end
          end
        end
        S_F_P: state_q <= S_F_PC;
        S_F_PC: begin
          if (ust_rd == US_FREE) begin
            nl_q      <= slen_rd;
            sub_seg_q <= p_q;
            sub_len_q <= slen_rd;
            ret_q     <= S_F_PM;
            state_q   <= S_RM0;
          end else begin
            state_q <= S_F_N;
          end
        end
        S_F_PM: begin
          cur_q   <= p_q;
          len_q   <= merged_prev;
          state_q <= S_F_N;
        end
        S_F_N: state_q <= (nxt_q < NO_LINK) ? S_F_NC : S_F_B;
        S_F_NC: begin
          if (ust_rd == US_FREE) begin
            nl_q      <= slen_rd;
            sub_seg_q <= nxt_q[AW-1:0];
            sub_len_q <= slen_rd;
            ret_q     <= S_F_NM;
            state_q   <= S_RM0;
          end else begin
            state_q <= S_F_B;
          end
        end
        S_F_NM: begin
          len_q   <= merged_next;
          nxt_q   <= nxt_q + nl_q;
          state_q <= S_F_B;
        end
        S_F_B: begin
          sub_seg_q <= cur_q;
          sub_len_q <= len_q;
          ret_q     <= S_MUL1;
          state_q   <= S_PU0;
        end
        S_MUL1: begin
          prod_q  <= PW'(seg_q) * PW'(unit_sz);
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          gaddr_q <= ((status_q == ST_OK) && (cmd_q == CMD_ALLOC)) ?
                     zone_base_q + prod_ext : '0;
          prod_q  <= PW'(held_q) * PW'(unit_sz);
          state_q <= S_RESP;
        end
        S_RESP: begin
          res_vld_q    <= 1'b1;
          res_status_q <= status_q;
          res_addr_q   <= gaddr_q;
          res_bytes_q  <= (prod_ext > 64'h7FFF_FFFF) ? '1 : prod_ext[BYTES_W-1:0];
          state_q      <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o    = res_vld_q;
  assign status_o          = res_status_q;
  assign granted_address_o = res_addr_q;
  assign bytes_in_use_o    = res_bytes_q;

  // A failed transaction never reports an address.
  a_err_no_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o != ST_OK)) |-> (granted_address_o == '0))
    else $error("address reported on a failed transaction");
  // Results are single-cycle pulses.
  a_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result shown twice");
  // The block goes busy as soon as a transaction is taken.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("not busy after accept");
  // The held-unit counter never exceeds the zone.
  a_held_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= NO_LINK) else $error("units held beyond zone size");

endmodule
`default_nettype wire

[dv/best_fit_segment_allocator_checker.sv]
// Checker of the best-fit segment allocator: shadow allocator and result comparison.
`timescale 1ns / 1ps
module best_fit_segment_allocator_checker #(
  parameter int unsigned NUM_UNITS = 1024
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start_i,
  input  wire        busy_i,
  input  wire        command_i,
  input  wire [31:0] request_bytes_i,
  input  wire [63:0] release_address_i,
  input  wire        result_valid_i,
  input  wire [2:0]  status_i,
  input  wire [63:0] granted_address_i,
  input  wire [30:0] bytes_in_use_i,
  input  wire        psel_i,
  input  wire        penable_i,
  input  wire        pwrite_i,
  input  wire        pready_i,
  input  wire [3:0]  paddr_i,
  input  wire [63:0] pwdata_i,
  output int         errors_o,
  output int         pending_o
);
  import bfsa_pkg::*;

  typedef struct {
    status_e     status;
    logic [63:0] address;
    logic [30:0] bytes;
  } alloc_result_t;

  localparam int unsigned NONE = NUM_UNITS;

  alloc_result_t expected_results[$];

  logic [20:0] unit_bytes;
  logic [63:0] zone_base;
  ustat_e      head_state[NUM_UNITS];
  int unsigned seg_len[NUM_UNITS];
  int unsigned back_dist[NUM_UNITS];
  int unsigned link_fwd[NUM_UNITS];
  int unsigned link_bwd[NUM_UNITS];
  int unsigned class_head[NUM_UNITS+1];
  bit          class_used[NUM_UNITS+1];
  int unsigned units_taken;

  assign pending_o = expected_results.size();

  function automatic logic [63:0] eff_unit_bytes();
    return (unit_bytes == 0) ? 64'd1 : 64'(unit_bytes);
  endfunction

  // Most recently freed or split segment goes to the front of its class.
  function automatic void push_size_class(int unsigned seg);
    int unsigned s;
    int unsigned h;
    s = seg_len[seg];
    if (s > NUM_UNITS) return;
    link_bwd[seg] = NONE;
    if (class_used[s]) begin
      h = class_head[s];
      link_fwd[seg] = h;
      if (h < NUM_UNITS) link_bwd[h] = seg;
    end else begin
      link_fwd[seg] = NONE;
    end
    class_head[s] = seg;
    class_used[s] = 1'b1;
  endfunction

  function automatic void unlink_size_class(int unsigned seg);
    int unsigned s;
    int unsigned p;
    int unsigned f;
    s = seg_len[seg];
    p = link_bwd[seg];
    f = link_fwd[seg];
    if (s > NUM_UNITS) return;
    if (p < NUM_UNITS) link_fwd[p] = f;
    else if (f < NUM_UNITS) class_head[s] = f;
    else class_used[s] = 1'b0;
    if (f < NUM_UNITS) link_bwd[f] = p;
  endfunction

  function automatic void clear_allocator();
    for (int i = 0; i < NUM_UNITS; i++) begin
      head_state[i] = US_INTERIOR;
      seg_len[i] = 0;
      back_dist[i] = 0;
      link_fwd[i] = NONE;
      link_bwd[i] = NONE;
    end
    for (int i = 0; i <= NUM_UNITS; i++) begin
      class_head[i] = 0;
      class_used[i] = 1'b0;
    end
    head_state[0] = US_FREE;
    seg_len[0] = NUM_UNITS;
    push_size_class(0);
    units_taken = 0;
  endfunction

  function automatic status_e alloc_segment(logic [31:0] req, output logic [63:0] addr);
    logic [63:0] u;
    logic [63:0] n64;
    int unsigned n;
    int unsigned s;
    int unsigned seg;
    int unsigned nxt;
    int unsigned nw;
    u = eff_unit_bytes();
    addr = '0;
    n64 = (64'(req) + u - 1) / u;
    if (n64 == 0) return ST_ZERO;
    if (n64 > NUM_UNITS) return ST_NOFIT;
    n = n64[31:0];
    for (s = n; s <= NUM_UNITS; s++) if (class_used[s]) break;
    if (s > NUM_UNITS) return ST_NOFIT;
    seg = class_head[s];
    if (seg >= NUM_UNITS) return ST_NOFIT;
    unlink_size_class(seg);
    head_state[seg] = US_FULL;
    if (s > n) begin
      nxt = seg + s;
      nw = seg + n;
      if (nxt < NUM_UNITS) back_dist[nxt] = s - n;
      if (nw < NUM_UNITS) begin
        head_state[nw] = US_FREE;
        back_dist[nw] = n;
        seg_len[nw] = s - n;
        push_size_class(nw);
      end
      seg_len[seg] = n;
    end
    units_taken += n;
    addr = zone_base + 64'(seg) * u;
    return ST_OK;
  endfunction

  // Returns a segment and merges it with free neighbors found by boundary tags.
  function automatic status_e release_segment(logic [63:0] a);
    logic [63:0] u;
    logic [63:0] off;
    int unsigned cur;
    int unsigned nxt;
    int unsigned len;
    int unsigned p;
    int unsigned nl;
    u = eff_unit_bytes();
    off = a - zone_base;
    if (off % u != 0 || off / u >= NUM_UNITS) return ST_BADADDR;
    cur = 32'(off / u);
    if (head_state[cur] == US_FREE) return ST_DBLFREE;
    if (head_state[cur] != US_FULL) return ST_BADADDR;
    len = seg_len[cur];
    units_taken = (units_taken >= len) ? units_taken - len : 0;
    head_state[cur] = US_FREE;
    nxt = cur + len;
    if (cur > 0 && back_dist[cur] <= cur && back_dist[cur] > 0) begin
      p = cur - back_dist[cur];
      if (head_state[p] == US_FREE) begin
        unlink_size_class(p);
        seg_len[p] += seg_len[cur];
        head_state[cur] = US_INTERIOR;
        cur = p;
      end
    end
    if (nxt < NUM_UNITS && head_state[nxt] == US_FREE) begin
      nl = seg_len[nxt];
      unlink_size_class(nxt);
      seg_len[cur] += nl;
      head_state[nxt] = US_INTERIOR;
      nxt += nl;
    end
    if (nxt < NUM_UNITS) back_dist[nxt] = seg_len[cur];
    push_size_class(cur);
    return ST_OK;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t exp_r;
    logic [63:0]   bytes64;
    if (!rst_ni) begin
      unit_bytes = 21'd64;
      zone_base = '0;
      clear_allocator();
      expected_results.delete();
      errors_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == 4'h0) unit_bytes = pwdata_i[20:0];
        else if (paddr_i == 4'h8) zone_base = pwdata_i;
      end
      if (result_valid_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no transaction outstanding");
          errors_o++;
        end else begin
          exp_r = expected_results.pop_front();
          if (status_i !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status_i);
            errors_o++;
          end
          if (granted_address_i !== exp_r.address) begin
            $error("granted_address: expected %h, got %h", exp_r.address, granted_address_i);
            errors_o++;
          end
          if (bytes_in_use_i !== exp_r.bytes) begin
            $error("bytes_in_use: expected %0d, got %0d", exp_r.bytes, bytes_in_use_i);
            errors_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        if (command_i == CMD_ALLOC) exp_r.status = alloc_segment(request_bytes_i, exp_r.address);
        else exp_r.status = release_segment(release_address_i);
        if (exp_r.status != ST_OK || command_i == CMD_FREE) exp_r.address = '0;
        bytes64 = 64'(units_taken) * eff_unit_bytes();
        exp_r.bytes = (bytes64 > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : bytes64[30:0];
        expected_results.push_back(exp_r);
      end
    end
  end
endmodule

[dv/best_fit_segment_allocator_core_tb.sv]
// Testbench top of the best-fit segment allocator: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module best_fit_segment_allocator_core_tb;
  import bfsa_pkg::*;

  localparam int unsigned UNITS = 1024;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        command_i = CMD_ALLOC;
  logic [31:0] request_bytes_i = '0;
  logic [63:0] release_address_i = '0;
  logic        result_valid_o;
  logic [2:0]  status_o;
  logic [63:0] granted_address_o;
  logic [30:0] bytes_in_use_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  int          mismatches;
  int          outstanding;

  // Addresses handed out by successful allocates and not yet freed.
  logic [63:0] live_segments[$];
  bit          last_was_alloc;
  logic [63:0] cur_unit;
  logic [63:0] cur_base;
  int          burst_left;

  best_fit_segment_allocator_core #(.NUM_UNITS(UNITS)) uut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .request_bytes_i, .release_address_i,
    .result_valid_o, .status_o, .granted_address_o, .bytes_in_use_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  best_fit_segment_allocator_checker #(.NUM_UNITS(UNITS)) checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .command_i, .request_bytes_i,
    .release_address_i, .result_valid_i(result_valid_o), .status_i(status_o),
    .granted_address_i(granted_address_o), .bytes_in_use_i(bytes_in_use_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata), .errors_o(mismatches), .pending_o(outstanding)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Harvest granted addresses so that later frees can hit real segments.
  always @(posedge clk_i) begin
    if (result_valid_o && last_was_alloc && status_o == ST_OK)
      live_segments.push_back(granted_address_o);
  end

  // The worst allocate scans every size class. The timeout budgets that for
  // every transaction plus sender gaps, several times over.
  initial begin
    #400_000_000;
    $display("best_fit_segment_allocator_core_tb: errors");
    $finish;
  end

  // Register write: setup cycle, then access cycle. Called at a falling edge.
  task automatic reg_write(input logic [3:0] addr, input logic [63:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Presents one transaction and holds it until the block takes it. Returns at
  // a falling edge with start still high, so the next transaction can follow.
  // The command kind is recorded only after the accepting edge, so a result
  // of the previous transaction at that same edge is still attributed to it.
  task automatic issue(input cmd_e cmd, input logic [31:0] req, input logic [63:0] addr);
    start = 1'b1;
    command_i = cmd;
    request_bytes_i = req;
    release_address_i = addr;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    @(negedge clk_i);
    last_was_alloc = (cmd == CMD_ALLOC);
  endtask

  // Sender pacing: bursts of random length separated by random gaps.
  task automatic pace(input int max_gap);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = int'($urandom_range(0, 7));
      gap = int'($urandom_range(0, 32'(max_gap)));
      if (gap > 0) begin
        start = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  task automatic drain();
    start = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Request sizes are mostly a few units; the byte count lands anywhere
  // inside the last unit so rounding is exercised.
  function automatic logic [31:0] pick_request();
    logic [63:0] n;
    logic [63:0] b;
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 70) n = 64'($urandom_range(1, 12));
    else if (r < 90) n = 64'($urandom_range(13, 96));
    else if (r < 96) n = 64'($urandom_range(97, UNITS));
    else return $urandom;
    b = n * cur_unit - 64'($urandom_range(0, 32'(cur_unit - 1)));
    return (b > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : b[31:0];
  endfunction

  task automatic random_phase(input int count, input int max_gap);
    int idx;
    int r;
    logic [63:0] a;
    for (int k = 0; k < count; k++) begin
      r = int'($urandom_range(0, 99));
      if (live_segments.size() > 0 && r < 42) begin
        idx = int'($urandom_range(0, 32'(live_segments.size() - 1)));
        a = live_segments[idx];
        live_segments.delete(idx);
        issue(CMD_FREE, $urandom, a);
      end else if (r < 88) begin
        issue(CMD_ALLOC, pick_request(), {$urandom, $urandom});
      end else begin
        // Noise: stale, misaligned, interior or wild addresses, and zero sizes.
        case ($urandom_range(0, 4))
          0: a = {$urandom, $urandom};
          1: a = cur_base + 64'($urandom_range(0, UNITS - 1)) * cur_unit;
          2: a = cur_base + 64'($urandom_range(0, UNITS - 1)) * cur_unit + 1;
          3: a = cur_base - cur_unit;
          default: a = cur_base + 64'(UNITS) * cur_unit;
        endcase
        if ($urandom_range(0, 3) == 0) issue(CMD_ALLOC, 32'd0, a);
        else issue(CMD_FREE, $urandom, a);
      end
      pace(max_gap);
    end
    drain();
  endtask

  task automatic set_zone(input logic [20:0] ub, input logic [63:0] base);
    reg_write(4'h0, {43'd0, ub});
    reg_write(4'h8, base);
    cur_unit = (ub == 0) ? 64'd1 : 64'(ub);
    cur_base = base;
    live_segments.delete();
  endtask

  initial begin
    burst_left = 0;
    last_was_alloc = 1'b0;
    cur_unit = 64;
    cur_base = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with the reset configuration.
    issue(CMD_ALLOC, 32'd0, '0);                       // zero size
    issue(CMD_ALLOC, 32'hFFFF_FFFF, '1);               // far too large
    issue(CMD_ALLOC, 32'd65537, '0);                   // one unit past the zone
    issue(CMD_ALLOC, 32'd65536, '0);                   // the whole zone
    issue(CMD_ALLOC, 32'd1, '0);                       // no fit, zone full
    issue(CMD_FREE, 32'd0, 64'd0);                     // free it again
    issue(CMD_FREE, 32'd0, 64'd0);                     // double free
    issue(CMD_ALLOC, 32'd1, '0);                       // unit 0
    issue(CMD_ALLOC, 32'd129, '0);                     // units 1..3
    issue(CMD_ALLOC, 32'd64, '0);                      // unit 4
    issue(CMD_FREE, 32'd0, 64'd128);                   // interior of a segment
    issue(CMD_FREE, 32'd0, 64'd65);                    // misaligned
    issue(CMD_FREE, 32'd0, 64'd65536);                 // beyond the zone
    issue(CMD_FREE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFC0); // below the base, wraps
    issue(CMD_FREE, 32'd0, 64'd0);                     // no free neighbor
    issue(CMD_FREE, 32'd0, 64'd256);                   // merges with the free tail
    issue(CMD_FREE, 32'd0, 64'd64);                    // merges on both sides
    issue(CMD_ALLOC, 32'd64, '0);
    drain();

    // Large units give large byte counts; a high base wraps the address.
    set_zone(21'h10_0000, 64'hFFFF_FFFF_FFF0_0000);
    issue(CMD_ALLOC, 32'hFFFF_FFFF, '0);
    issue(CMD_ALLOC, 32'h0010_0001, '0);
    drain();
    random_phase(150, 4);

    set_zone(21'd0, {$urandom, $urandom});             // zero unit size acts as one
    random_phase(180, 0);
    set_zone(21'h1F_FFFF, {$urandom, $urandom});
    random_phase(180, 6);
    set_zone(21'd1, 64'd0);
    random_phase(180, 3);
    set_zone(21'($urandom_range(2, 300)), {$urandom, $urandom});
    random_phase(180, 5);
    set_zone(21'd64, 64'hFFFF_FFFF_FFFF_FFFF);
    random_phase(180, 2);

    if (mismatches == 0) begin
      $display("best_fit_segment_allocator_core_tb: clean");
    end else begin
      $display("best_fit_segment_allocator_core_tb: errors");
    end
    $finish;
  end
endmodule

[best_fit_segment_allocator_core.f]
src/bfsa_pkg.sv
src/bfsa_div.sv
src/best_fit_segment_allocator_core.sv
dv/best_fit_segment_allocator_checker.sv
dv/best_fit_segment_allocator_core_tb.sv
